### hw/rtl/static_range_encoder_bytes_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the static range encoder
// Concurrent assertion shorthands clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef STATIC_RANGE_ENCODER_BYTES_TOP_ASSERT_SVH
`define STATIC_RANGE_ENCODER_BYTES_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define SRENC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("srenc assertion failed");
`define SRENC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("srenc assertion failed");
`else
`define SRENC_ASSERT_IMP(lbl, ante, cons)
`define SRENC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

### hw/rtl/srenc_pkg.sv
// ----------------------------------------------------------------------------
// Static range encoder package
// Operation codes, command and status types, and coder constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package srenc_pkg;

  typedef enum logic [2:0] {
    OP_COUNT  = 3'd0,
    OP_BUILD  = 3'd1,
    OP_ENCODE = 3'd2,
    OP_FLUSH  = 3'd3,
    OP_READ   = 3'd4
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CNT_WR,
    ST_BLD_RD,
    ST_BLD_WR,
    ST_DIV,
    ST_ENC_A,
    ST_ENC_B,
    ST_ENC_M1,
    ST_ENC_M2,
    ST_NORM,
    ST_FLUSH,
    ST_RD_OUT
  } state_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] sym;
    logic [8:0] idx;
  } cmd_t;

  typedef struct packed {
    logic [1:0] level;
  } front_stat_t;

  typedef struct packed {
    logic busy;
    logic built;
  } back_stat_t;

  localparam logic [31:0] TOP_LIMIT    = 32'h0100_0000;
  localparam logic [31:0] BOTTOM_LIMIT = 32'h0001_0000;
  localparam logic [31:0] MAX_TOTAL    = 32'h0001_0000;
  localparam logic [1:0]  QUEUE_DEPTH  = 2'd2;
  localparam logic [2:0]  MAX_BYTES    = 3'd4;

endpackage

### hw/rtl/srenc_front.sv
// ----------------------------------------------------------------------------
// Static range encoder front end
// Accepts input transactions, drops unknown opcodes and queues the rest.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module srenc_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [2:0]               opcode_i,
  input  logic [7:0]               symbol_i,
  input  logic [8:0]               table_index_i,
  input  logic                     pop_i,
  output logic                     q_valid_o,
  output srenc_pkg::cmd_t          q_cmd_o,
  output srenc_pkg::front_stat_t   stat_o
);
  import srenc_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] level_q, level_d;
  logic       known;
  logic       push;
  cmd_t       cmd;

  always_comb begin
    case (opcode_i)
      OP_COUNT, OP_BUILD, OP_ENCODE, OP_FLUSH, OP_READ: known = 1'b1;
      default: known = 1'b0;
    endcase
    cmd.op  = op_e'(opcode_i);
    cmd.sym = symbol_i;
    cmd.idx = table_index_i;
  end

  assign in_stall_o   = (level_q == QUEUE_DEPTH);
  assign push         = in_valid_i && !in_stall_o && known;
  assign q_valid_o    = (level_q != 2'd0);
  assign q_cmd_o      = mem_q[rd_ptr_q];
  assign stat_o.level = level_q;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    level_d  = level_q + {1'b0, push} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      level_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= cmd;
    end
  end

endmodule

### hw/rtl/srenc_back.sv
// ----------------------------------------------------------------------------
// Static range encoder back end
// Executes queued commands: histogram, table build, encode, flush and read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module srenc_back #(
  parameter int SYMBOL_COUNT = 256,
  parameter int COUNT_BITS   = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    q_valid_i,
  input  srenc_pkg::cmd_t         q_cmd_i,
  output logic                    pop_o,
  output srenc_pkg::back_stat_t   stat_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [7:0]              out_byte_o,
  output logic [15:0]             table_word_o,
  output logic                    last_o
);
  import srenc_pkg::*;

  localparam int HIDX_W = $clog2(SYMBOL_COUNT);
  localparam int TIDX_W = $clog2(SYMBOL_COUNT + 1);
  localparam int ACC_W  = COUNT_BITS + TIDX_W;

  logic [COUNT_BITS-1:0] hist_mem [SYMBOL_COUNT];
  logic [ACC_W-1:0]      tbl_mem  [SYMBOL_COUNT + 1];

  state_e                state_q, state_d;
  logic [SYMBOL_COUNT-1:0] hvalid_q, hvalid_d;
  logic                  built_q, built_d;
  logic [15:0]           total_q, total_d;
  logic [31:0]           low_q, low_d;
  logic [31:0]           range_q, range_d;
  logic                  any_q, any_d;
  logic [2:0]            n_q, n_d;
  logic                  pend_q, pend_d;
  logic                  pass0_q, pass0_d;
  logic                  out_valid_q, out_valid_d;

  logic [7:0]            sym_q, sym_d;
  logic [TIDX_W-1:0]     f_q, f_d;
  logic [ACC_W-1:0]      prev_q, prev_d;
  logic [15:0]           rem_q, rem_d;
  logic [31:0]           dvd_q, dvd_d;
  logic [4:0]            dcnt_q, dcnt_d;
  logic [15:0]           ca_q, ca_d;
  logic [15:0]           cb_q, cb_d;
  logic [7:0]            pend_byte_q, pend_byte_d;
  logic                  rd_ok_q, rd_ok_d;
  logic [7:0]            out_byte_q;
  logic [15:0]           out_word_q;
  logic                  out_last_q;

  logic [HIDX_W-1:0]     hist_ra, hist_wa;
  logic                  hist_we;
  logic [COUNT_BITS-1:0] hist_wd, hist_rd_q;
  logic                  hv_q;
  logic [TIDX_W-1:0]     tbl_ra, tbl_wa;
  logic                  tbl_we;
  logic [ACC_W-1:0]      tbl_wd, tbl_rd_q;

  logic                  emit;
  logic [7:0]            emit_byte;
  logic [15:0]           emit_word;
  logic                  emit_last;
  logic                  slot_free;

  logic                  cmd_sym_ok;
  logic                  cmd_idx_ok;
  logic [COUNT_BITS-1:0] hcur;
  logic [ACC_W-1:0]      cand, newv;
  logic [TIDX_W-1:0]     fm1;
  logic [16:0]           rem_sh;
  logic                  qbit;
  logic [47:0]           prod1, prod2;
  logic [15:0]           slice;
  logic [31:0]           lsum;
  logic                  go_top, go_bot, go;
  logic [31:0]           range_adj;

  assign slot_free  = !out_valid_q || !out_stall_i;
  assign cmd_sym_ok = int'(q_cmd_i.sym) < SYMBOL_COUNT;
  assign cmd_idx_ok = int'(q_cmd_i.idx) <= SYMBOL_COUNT;

  always_comb begin
    hcur   = hv_q ? hist_rd_q : '0;
    cand   = pass0_q ? (prev_q + ACC_W'(hcur)) : (tbl_rd_q >> 1);
    newv   = (cand <= prev_q) ? (prev_q + ACC_W'(1)) : cand;
    fm1    = f_q - TIDX_W'(1);
    rem_sh = {rem_q, dvd_q[31]};
    qbit   = (rem_sh >= {1'b0, total_q});
    prod1  = 48'(ca_q) * 48'(dvd_q);
    slice  = cb_q - ca_q;
    prod2  = 48'(slice) * 48'(dvd_q);
    lsum   = low_q + range_q;
    go_top = ((low_q ^ lsum) < TOP_LIMIT);
    go_bot = (range_q < BOTTOM_LIMIT);
    go     = (n_q < MAX_BYTES) && (go_top || go_bot);
    range_adj = go_top ? range_q : ((32'd0 - low_q) & (BOTTOM_LIMIT - 32'd1));
  end

  always_comb begin
    state_d     = state_q;
    hvalid_d    = hvalid_q;
    built_d     = built_q;
    total_d     = total_q;
    low_d       = low_q;
    range_d     = range_q;
    any_d       = any_q;
    n_d         = n_q;
    pend_d      = pend_q;
    pass0_d     = pass0_q;
    sym_d       = sym_q;
    f_d         = f_q;
    prev_d      = prev_q;
    rem_d       = rem_q;
    dvd_d       = dvd_q;
    dcnt_d      = dcnt_q;
    ca_d        = ca_q;
    cb_d        = cb_q;
    pend_byte_d = pend_byte_q;
    rd_ok_d     = rd_ok_q;
    pop_o       = 1'b0;
    hist_ra     = '0;
    hist_wa     = sym_q[HIDX_W-1:0];
    hist_we     = 1'b0;
    hist_wd     = (hcur == '1) ? hcur : (hcur + COUNT_BITS'(1));
    tbl_ra      = '0;
    tbl_wa      = f_q;
    tbl_we      = 1'b0;
    tbl_wd      = newv;
    emit        = 1'b0;
    emit_byte   = 8'd0;
    emit_word   = 16'd0;
    emit_last   = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          pop_o   = 1'b1;
          sym_d   = q_cmd_i.sym;
          hist_ra = q_cmd_i.sym[HIDX_W-1:0];
          tbl_ra  = q_cmd_i.idx[TIDX_W-1:0];
          case (q_cmd_i.op)
            OP_COUNT: begin
              if (cmd_sym_ok) begin
                any_d   = 1'b1;
                state_d = ST_CNT_WR;
              end
            end
            OP_BUILD: begin
              tbl_we  = 1'b1;
              tbl_wa  = '0;
              tbl_wd  = '0;
              prev_d  = '0;
              f_d     = TIDX_W'(1);
              pass0_d = 1'b1;
              state_d = ST_BLD_RD;
            end
            OP_ENCODE: begin
              if (cmd_sym_ok && built_q) begin
                rem_d   = '0;
                dvd_d   = range_q;
                dcnt_d  = '0;
                state_d = ST_DIV;
              end
            end
            OP_FLUSH: begin
              n_d     = '0;
              state_d = ST_FLUSH;
            end
            OP_READ: begin
              rd_ok_d = built_q && cmd_idx_ok;
              f_d     = q_cmd_i.idx[TIDX_W-1:0];
              state_d = ST_RD_OUT;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_CNT_WR: begin
        hist_we = 1'b1;
        hvalid_d[sym_q[HIDX_W-1:0]] = 1'b1;
        state_d = ST_IDLE;
      end
      ST_BLD_RD: begin
        hist_ra = fm1[HIDX_W-1:0];
        tbl_ra  = f_q;
        state_d = ST_BLD_WR;
      end
      ST_BLD_WR: begin
        tbl_we = 1'b1;
        prev_d = newv;
        if (f_q == TIDX_W'(SYMBOL_COUNT)) begin
          if (newv >= ACC_W'(MAX_TOTAL)) begin
            pass0_d = 1'b0;
            prev_d  = '0;
            f_d     = TIDX_W'(1);
            state_d = ST_BLD_RD;
          end else begin
            total_d = newv[15:0];
            built_d = 1'b1;
            state_d = ST_IDLE;
          end
        end else begin
          f_d     = f_q + TIDX_W'(1);
          state_d = ST_BLD_RD;
        end
      end
      ST_DIV: begin
        rem_d  = qbit ? 16'(rem_sh - {1'b0, total_q}) : rem_sh[15:0];
        dvd_d  = {dvd_q[30:0], qbit};
        dcnt_d = dcnt_q + 5'd1;
        if (dcnt_q == 5'd31) begin
          state_d = ST_ENC_A;
        end
      end
      ST_ENC_A: begin
        tbl_ra  = TIDX_W'(sym_q);
        state_d = ST_ENC_B;
      end
      ST_ENC_B: begin
        ca_d    = tbl_rd_q[15:0];
        tbl_ra  = TIDX_W'(sym_q) + TIDX_W'(1);
        state_d = ST_ENC_M1;
      end
      ST_ENC_M1: begin
        cb_d    = tbl_rd_q[15:0];
        low_d   = low_q + prod1[31:0];
        state_d = ST_ENC_M2;
      end
      ST_ENC_M2: begin
        range_d = prod2[31:0];
        n_d     = '0;
        pend_d  = 1'b0;
        state_d = ST_NORM;
      end
      ST_NORM: begin
        if (go) begin
          if (!pend_q || slot_free) begin
            emit        = pend_q;
            emit_byte   = pend_byte_q;
            pend_byte_d = low_q[31:24];
            pend_d      = 1'b1;
            low_d       = low_q << 8;
            range_d     = range_adj << 8;
            n_d         = n_q + 3'd1;
          end
        end else if (!pend_q) begin
          state_d = ST_IDLE;
        end else if (slot_free) begin
          emit      = 1'b1;
          emit_byte = pend_byte_q;
          emit_last = 1'b1;
          pend_d    = 1'b0;
          state_d   = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (!any_q) begin
          hvalid_d = '0;
          low_d    = '0;
          range_d  = '1;
          state_d  = ST_IDLE;
        end else if (slot_free) begin
          emit      = 1'b1;
          emit_byte = low_q[31:24];
          emit_last = (n_q == 3'd3);
          low_d     = low_q << 8;
          n_d       = n_q + 3'd1;
          if (n_q == 3'd3) begin
            hvalid_d = '0;
            low_d    = '0;
            range_d  = '1;
            any_d    = 1'b0;
            state_d  = ST_IDLE;
          end
        end
      end
      ST_RD_OUT: begin
        tbl_ra = f_q;
        if (slot_free) begin
          emit      = 1'b1;
          emit_word = rd_ok_q ? tbl_rd_q[15:0] : 16'd0;
          emit_last = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    out_valid_d = emit ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      hvalid_q    <= '0;
      built_q     <= 1'b0;
      total_q     <= '0;
      low_q       <= '0;
      range_q     <= '1;
      any_q       <= 1'b0;
      n_q         <= '0;
      pend_q      <= 1'b0;
      pass0_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hvalid_q    <= hvalid_d;
      built_q     <= built_d;
      total_q     <= total_d;
      low_q       <= low_d;
      range_q     <= range_d;
      any_q       <= any_d;
      n_q         <= n_d;
      pend_q      <= pend_d;
      pass0_q     <= pass0_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q       <= sym_d;
    f_q         <= f_d;
    prev_q      <= prev_d;
    rem_q       <= rem_d;
    dvd_q       <= dvd_d;
    dcnt_q      <= dcnt_d;
    ca_q        <= ca_d;
    cb_q        <= cb_d;
    pend_byte_q <= pend_byte_d;
    rd_ok_q     <= rd_ok_d;
    if (emit) begin
      out_byte_q <= emit_byte;
      out_word_q <= emit_word;
      out_last_q <= emit_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hist_we) begin
      hist_mem[hist_wa] <= hist_wd;
    end
    hist_rd_q <= hist_mem[hist_ra];
    hv_q      <= hvalid_q[hist_ra];
  end

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_mem[tbl_wa] <= tbl_wd;
    end
    tbl_rd_q <= tbl_mem[tbl_ra];
  end

  assign stat_o.busy   = (state_q != ST_IDLE);
  assign stat_o.built  = built_q;
  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign table_word_o  = out_word_q;
  assign last_o        = out_last_q;

endmodule

### hw/rtl/static_range_encoder_bytes_top.sv
// Flush emits the four bytes of low, or none when nothing was counted.
// Encode runs the 32-step divider and the table reads, then normalizes and emits its bytes.
// Build runs one summing pass, then halving passes while the total is at least MAX_TOTAL.
// A two-entry command queue lets input transactions arrive while the back end works.
// Reset is asynchronous and active low; the histogram clears at once through valid
// bits, so there is no clearing pass.
// ----------------------------------------------------------------------------
// Static range encoder top level
// Byte-alphabet static range coder with histogram, table build and encode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "static_range_encoder_bytes_top_assert.svh"
module static_range_encoder_bytes_top #(
  parameter int SYMBOL_COUNT = 256,
  parameter int COUNT_BITS   = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  opcode_i,
  input  logic [7:0]  symbol_i,
  input  logic [8:0]  table_index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic [15:0] table_word_o,
  output logic        last_o
);
  import srenc_pkg::*;

  logic        q_valid;
  logic        pop;
  cmd_t        q_cmd;
  front_stat_t f_stat;
  back_stat_t  b_stat;

  srenc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .opcode_i      (opcode_i),
    .symbol_i      (symbol_i),
    .table_index_i (table_index_i),
    .pop_i         (pop),
    .q_valid_o     (q_valid),
    .q_cmd_o       (q_cmd),
    .stat_o        (f_stat)
  );

  srenc_back #(
    .SYMBOL_COUNT (SYMBOL_COUNT),
    .COUNT_BITS   (COUNT_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_cmd_i      (q_cmd),
    .pop_o        (pop),
    .stat_o       (b_stat),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .table_word_o (table_word_o),
    .last_o       (last_o)
  );

  `SRENC_ASSERT_IMP(a_queue_bound, 1'b1, f_stat.level <= QUEUE_DEPTH)
  `SRENC_ASSERT_IMP(a_pop_needs_entry, pop, q_valid && !b_stat.busy)
  `SRENC_ASSERT_NXT(a_built_sticky, b_stat.built, b_stat.built)

endmodule
